>>> rtl/multi_queue_max_heap_drain_assert.svh
// ----------------------------------------------------------------------------
// multi_queue_max_heap_drain_assert
// assertion macros for the top rtl file, sampled on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef MULTI_QUEUE_MAX_HEAP_DRAIN_ASSERT_SVH
`define MULTI_QUEUE_MAX_HEAP_DRAIN_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define MQHD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define MQHD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MQHD_ASSERT_IMPL(lbl, ante, cons, msg)
`define MQHD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/mqhd_pkg.sv
// ----------------------------------------------------------------------------
// mqhd_pkg
// types and constants of the multi-queue max-heap drain
// ----------------------------------------------------------------------------
package mqhd_pkg;

	localparam int NUM_QUEUES  = 8;
	localparam int QUEUE_DEPTH = 16;

	localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int AW = QW + IW;
	localparam int VW = 16;

	localparam logic [3:0] RANK_LIMIT = 4'd15;
	localparam logic [2:0] RANK_MAX   = 3'd7;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_POP    = 1'b1;

	typedef logic [QW-1:0] qidx_t;
	typedef logic [IW-1:0] hidx_t;
	typedef logic [CW-1:0] cnt_t;
	typedef logic [AW-1:0] addr_t;
	typedef logic [VW-1:0] val_t;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_POPPED   = 2'd1,
		ST_FULL     = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef struct packed {
		logic       action;
		logic [2:0] queue_sel;
		val_t       value;
	} req_t;

	typedef struct packed {
		status_t    status;
		val_t       out_value;
		logic [2:0] source_queue;
		logic       queue_emptied;
		logic [2:0] empty_rank;
	} rsp_t;

	typedef struct packed {
		logic  wr_en;
		addr_t wr_addr;
		val_t  wr_data;
		logic  rd_en;
		addr_t rd_addr;
	} mem_cmd_t;

endpackage

>>> rtl/multi_queue_max_heap_drain.sv
// ----------------------------------------------------------------------------
// multi_queue_max_heap_drain
// Eight bounded max-heap queues of up to sixteen 16-bit values, held in one
// heap ram with a registered read. One transaction is worked on at a time; req
// is stalled until its result has entered the output register, which frees the
// input while the result waits. An insert reads the parent and moves the value
// up a level while the parent is smaller, writing as it goes. A pop scans every
// queue head through the ram read port, then sifts the last entry down, reading
// the left and right child at each level; a pop on empty queues or a pop that
// empties its queue ends after the scan. Entry counts reset to zero at once;
// the ram needs no clearing.
// ----------------------------------------------------------------------------
`include "multi_queue_max_heap_drain_assert.svh"

module multi_queue_max_heap_drain (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  mqhd_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output mqhd_pkg::rsp_t rsp
);

	mqhd_pkg::mem_cmd_t cmd;
	mqhd_pkg::val_t     rd_data;
	logic               res_ready;
	logic               res_valid;
	mqhd_pkg::rsp_t     res;
	logic               rsp_valid_q;
	mqhd_pkg::rsp_t     rsp_q;

	mqhd_ram u_ram (
		.clk     (clk),
		.cmd     (cmd),
		.rd_data (rd_data)
	);

	mqhd_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_stall (req_stall),
		.cmd       (cmd),
		.rd_data   (rd_data),
		.res_ready (res_ready),
		.res_valid (res_valid),
		.res       (res)
	);

	// output register
	assign res_ready = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (res_valid) begin
				rsp_valid_q <= 1'b1;
				rsp_q       <= res;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`MQHD_ASSERT_IMPL(a_res_slot_free, res_valid, res_ready, "result while output register full")
	`MQHD_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "no stall after accept")
	`MQHD_ASSERT_IMPL(a_non_pop_fields, rsp_valid && rsp.status != mqhd_pkg::ST_POPPED, rsp.out_value == 16'd0 && rsp.queue_emptied == 1'b0, "pop fields set on non-pop result")
	`MQHD_ASSERT_IMPL(a_engine_only_idle_takes, res_valid, req_stall, "result while engine idle")

endmodule

>>> rtl/mqhd_ram.sv
// ----------------------------------------------------------------------------
// mqhd_ram
// heap storage of all queues, one write and one registered read port
// ----------------------------------------------------------------------------
module mqhd_ram (
	input  logic              clk,
	input  mqhd_pkg::mem_cmd_t cmd,
	output mqhd_pkg::val_t     rd_data
);

	mqhd_pkg::val_t mem [2**mqhd_pkg::AW];

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[cmd.wr_addr] <= cmd.wr_data;
		end
		if (cmd.rd_en) begin
			rd_data <= mem[cmd.rd_addr];
		end
	end

endmodule

>>> rtl/mqhd_engine.sv
// ----------------------------------------------------------------------------
// mqhd_engine
// sequencer for insert sift-up, head scan and pop sift-down over the heap ram
// ----------------------------------------------------------------------------
module mqhd_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  mqhd_pkg::req_t     req,
	output logic               req_stall,
	output mqhd_pkg::mem_cmd_t cmd,
	input  mqhd_pkg::val_t     rd_data,
	input  logic               res_ready,
	output logic               res_valid,
	output mqhd_pkg::rsp_t     res
);

	typedef enum logic [3:0] {
		S_IDLE, S_UP_RD, S_UP_CMP, S_SCAN, S_SCAN_END, S_POP_SEL,
		S_POP_LAST, S_DN_RDL, S_DN_RDR, S_DN_CMP, S_FIN
	} state_t;

	typedef logic [mqhd_pkg::IW+1:0] xidx_t;

	state_t          state_q;
	mqhd_pkg::qidx_t q_q;
	mqhd_pkg::hidx_t pos_q;
	mqhd_pkg::val_t  mv_q;
	mqhd_pkg::val_t  lv_q;
	mqhd_pkg::cnt_t  n_q;
	logic            r_ok_q;
	mqhd_pkg::qidx_t sq_q;
	logic            scan_vld_s1;
	mqhd_pkg::qidx_t scan_q_s1;
	logic            found_q;
	mqhd_pkg::val_t  best_v_q;
	mqhd_pkg::qidx_t best_q_q;
	mqhd_pkg::cnt_t  cnt_q [mqhd_pkg::NUM_QUEUES];
	logic [3:0]      emptied_q;
	mqhd_pkg::rsp_t  res_q;

	mqhd_pkg::qidx_t cidx;
	mqhd_pkg::cnt_t  cnt_rd;
	mqhd_pkg::cnt_t  cnt_dec;
	mqhd_pkg::hidx_t par;
	xidx_t           l_x;
	xidx_t           r_x;
	xidx_t           n_x;
	logic            lbig;
	logic            rbig;
	mqhd_pkg::val_t  cand;
	logic            bad_ins;
	mqhd_pkg::rsp_t  res_d;

	assign req_stall = (state_q != S_IDLE);
	assign res_valid = (state_q == S_FIN) && res_ready;
	assign res       = res_q;

	always_comb begin
		case (state_q)
			S_IDLE:  cidx = mqhd_pkg::qidx_t'(req.queue_sel);
			S_SCAN:  cidx = sq_q;
			default: cidx = best_q_q;
		endcase
	end

	assign cnt_rd  = cnt_q[cidx];
	assign cnt_dec = cnt_rd - mqhd_pkg::cnt_t'(1);
	assign par     = mqhd_pkg::hidx_t'((pos_q - mqhd_pkg::hidx_t'(1)) >> 1);
	assign l_x     = {1'b0, pos_q, 1'b1};
	assign r_x     = {1'b0, pos_q, 1'b0} + xidx_t'(2);
	assign n_x     = xidx_t'(n_q);
	assign lbig    = lv_q > mv_q;
	assign cand    = lbig ? lv_q : mv_q;
	assign rbig    = r_ok_q && (rd_data > cand);
	assign bad_ins = (int'(req.queue_sel) >= mqhd_pkg::NUM_QUEUES) ||
		(cnt_rd == mqhd_pkg::cnt_t'(mqhd_pkg::QUEUE_DEPTH));

	// result of the transaction, taken in idle or at pop select
	always_comb begin
		res_d = '0;
		if (state_q == S_IDLE) begin
			res_d.status = bad_ins ? mqhd_pkg::ST_FULL : mqhd_pkg::ST_INSERTED;
		end else if (!found_q) begin
			res_d.status = mqhd_pkg::ST_EMPTY;
		end else begin
			res_d.status       = mqhd_pkg::ST_POPPED;
			res_d.out_value    = best_v_q;
			res_d.source_queue = 3'(best_q_q);
			if (cnt_dec == '0) begin
				res_d.queue_emptied = 1'b1;
				res_d.empty_rank    = (emptied_q > 4'(mqhd_pkg::RANK_MAX)) ?
					mqhd_pkg::RANK_MAX : emptied_q[2:0];
			end
		end
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			S_UP_RD: begin
				if (pos_q == '0) begin
					cmd.wr_en   = 1'b1;
					cmd.wr_addr = {q_q, pos_q};
					cmd.wr_data = mv_q;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_addr = {q_q, par};
				end
			end
			S_UP_CMP: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_addr = {q_q, pos_q};
				cmd.wr_data = (rd_data < mv_q) ? rd_data : mv_q;
			end
			S_SCAN: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = {sq_q, mqhd_pkg::hidx_t'(0)};
			end
			S_POP_SEL: begin
				if (found_q && cnt_dec != '0) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_addr = {best_q_q, mqhd_pkg::hidx_t'(cnt_dec)};
				end
			end
			S_DN_RDL: begin
				if (l_x >= n_x) begin
					cmd.wr_en   = 1'b1;
					cmd.wr_addr = {q_q, pos_q};
					cmd.wr_data = mv_q;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_addr = {q_q, l_x[mqhd_pkg::IW-1:0]};
				end
			end
			S_DN_RDR: begin
				if (r_x < n_x) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_addr = {q_q, r_x[mqhd_pkg::IW-1:0]};
				end
			end
			S_DN_CMP: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_addr = {q_q, pos_q};
				cmd.wr_data = rbig ? rd_data : (lbig ? lv_q : mv_q);
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			q_q         <= '0;
			pos_q       <= '0;
			mv_q        <= '0;
			lv_q        <= '0;
			n_q         <= '0;
			r_ok_q      <= 1'b0;
			sq_q        <= '0;
			scan_vld_s1 <= 1'b0;
			scan_q_s1   <= '0;
			found_q     <= 1'b0;
			best_v_q    <= '0;
			best_q_q    <= '0;
			emptied_q   <= '0;
			res_q       <= '0;
			for (int i = 0; i < mqhd_pkg::NUM_QUEUES; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			// head compare, in the cycle after the scan read
			if (scan_vld_s1 && (!found_q || rd_data > best_v_q)) begin
				found_q  <= 1'b1;
				best_v_q <= rd_data;
				best_q_q <= scan_q_s1;
			end
			scan_vld_s1 <= (state_q == S_SCAN) && (cnt_rd != '0);
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						if (req.action == mqhd_pkg::ACT_POP) begin
							sq_q    <= '0;
							found_q <= 1'b0;
							state_q <= S_SCAN;
						end else if (bad_ins) begin
							res_q   <= res_d;
							state_q <= S_FIN;
						end else begin
							cnt_q[cidx] <= cnt_rd + mqhd_pkg::cnt_t'(1);
							q_q         <= cidx;
							pos_q       <= mqhd_pkg::hidx_t'(cnt_rd);
							mv_q        <= req.value;
							res_q       <= res_d;
							state_q     <= S_UP_RD;
						end
					end
				end
				S_UP_RD: begin
					state_q <= (pos_q == '0) ? S_FIN : S_UP_CMP;
				end
				S_UP_CMP: begin
					if (rd_data < mv_q) begin
						pos_q   <= par;
						state_q <= S_UP_RD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_SCAN: begin
					scan_q_s1 <= sq_q;
					if (sq_q == mqhd_pkg::qidx_t'(mqhd_pkg::NUM_QUEUES - 1)) begin
						state_q <= S_SCAN_END;
					end else begin
						sq_q <= sq_q + mqhd_pkg::qidx_t'(1);
					end
				end
				S_SCAN_END: begin
					state_q <= S_POP_SEL;
				end
				S_POP_SEL: begin
					res_q <= res_d;
					if (!found_q) begin
						state_q <= S_FIN;
					end else begin
						cnt_q[best_q_q] <= cnt_dec;
						n_q             <= cnt_dec;
						q_q             <= best_q_q;
						if (cnt_dec == '0) begin
							if (emptied_q < mqhd_pkg::RANK_LIMIT) begin
								emptied_q <= emptied_q + 4'd1;
							end
							state_q <= S_FIN;
						end else begin
							state_q <= S_POP_LAST;
						end
					end
				end
				S_POP_LAST: begin
					mv_q    <= rd_data;
					pos_q   <= '0;
					state_q <= S_DN_RDL;
				end
				S_DN_RDL: begin
					state_q <= (l_x >= n_x) ? S_FIN : S_DN_RDR;
				end
				S_DN_RDR: begin
					lv_q    <= rd_data;
					r_ok_q  <= (r_x < n_x);
					state_q <= S_DN_CMP;
				end
				S_DN_CMP: begin
					if (lbig || rbig) begin
						pos_q   <= rbig ? r_x[mqhd_pkg::IW-1:0] : l_x[mqhd_pkg::IW-1:0];
						state_q <= S_DN_RDL;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
